>>> rtl/tscc_pkg.sv
// ----------------------------------------------------------------------------
// tscc_pkg
// Types, codes and constants shared by the three-stage charge controller.
// ----------------------------------------------------------------------------
package tscc_pkg;

   localparam int CMD_W     = 2;
   localparam int READING_W = 10;
   localparam int SECONDS_W = 16;
   localparam int TICK_W    = 8;
   localparam int PHASE_W   = 3;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CMD_W-1:0] {
      CMD_SAMPLE     = 2'd0,
      CMD_TICK       = 2'd1,
      CMD_DISCONNECT = 2'd2,
      CMD_START      = 2'd3
   } cmd_type;

   // Internal phase register, one-hot
   typedef enum logic [6:0] {
      PH_IDLE       = 7'b000_0001,
      PH_BULK       = 7'b000_0010,
      PH_ABSORB     = 7'b000_0100,
      PH_FLOAT      = 7'b000_1000,
      PH_COMPLETE   = 7'b001_0000,
      PH_ALARM      = 7'b010_0000,
      PH_DISCONNECT = 7'b100_0000
   } phase_type;

   // Phase codes as shown on the result word
   localparam logic [PHASE_W-1:0] PHASE_CODE_IDLE       = 3'd0;
   localparam logic [PHASE_W-1:0] PHASE_CODE_BULK       = 3'd1;
   localparam logic [PHASE_W-1:0] PHASE_CODE_ABSORB     = 3'd2;
   localparam logic [PHASE_W-1:0] PHASE_CODE_FLOAT      = 3'd3;
   localparam logic [PHASE_W-1:0] PHASE_CODE_COMPLETE   = 3'd4;
   localparam logic [PHASE_W-1:0] PHASE_CODE_ALARM      = 3'd5;
   localparam logic [PHASE_W-1:0] PHASE_CODE_DISCONNECT = 3'd6;

   // Register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_TRICKLE_MODE      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ABSORB_VOLT_LEVEL = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OVERVOLT_LEVEL    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OVERTEMP_LEVEL    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ABSORB_SECONDS    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FLOAT_SECONDS     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_TICKS_PER_SECOND  = 3'd6;

   localparam logic [READING_W-1:0] RST_ABSORB_VOLT_LEVEL = 10'd983;
   localparam logic [READING_W-1:0] RST_OVERVOLT_LEVEL    = 10'd989;
   localparam logic [READING_W-1:0] RST_OVERTEMP_LEVEL    = 10'd92;
   localparam logic [SECONDS_W-1:0] RST_ABSORB_SECONDS    = 16'd30;
   localparam logic [SECONDS_W-1:0] RST_FLOAT_SECONDS     = 16'd5;
   localparam logic [TICK_W-1:0]    RST_TICKS_PER_SECOND  = 8'd63;

   typedef struct packed {
      logic                 trickle_mode;
      logic [READING_W-1:0] absorb_volt_level;
      logic [READING_W-1:0] overvolt_level;
      logic [READING_W-1:0] overtemp_level;
      logic [SECONDS_W-1:0] absorb_seconds;
      logic [SECONDS_W-1:0] float_seconds;
      logic [TICK_W-1:0]    ticks_per_second;
   } cfg_type;

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic               charger_on;
      logic               alarm_led;
      logic               complete_led;
      logic               over_temp;
   } status_type;

   function automatic logic [PHASE_W-1:0] phase_code(input phase_type ph);
      logic [PHASE_W-1:0] code;
      unique case (ph)
         PH_IDLE:       code = PHASE_CODE_IDLE;
         PH_BULK:       code = PHASE_CODE_BULK;
         PH_ABSORB:     code = PHASE_CODE_ABSORB;
         PH_FLOAT:      code = PHASE_CODE_FLOAT;
         PH_COMPLETE:   code = PHASE_CODE_COMPLETE;
         PH_ALARM:      code = PHASE_CODE_ALARM;
         PH_DISCONNECT: code = PHASE_CODE_DISCONNECT;
         default:       code = PHASE_CODE_IDLE;
      endcase
      return code;
   endfunction

   function automatic logic [SECONDS_W-1:0] sat_inc(input logic [SECONDS_W-1:0] v);
      return (v == {SECONDS_W{1'b1}}) ? v : v + SECONDS_W'(1);
   endfunction

endpackage

>>> rtl/tscc_if.sv
// ----------------------------------------------------------------------------
// tscc_req_if / tscc_rsp_if
// Valid/ready channels carrying request and response words.
// ----------------------------------------------------------------------------
interface tscc_req_if import tscc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CMD_W-1:0]     cmd;
   logic [READING_W-1:0] volt_reading;
   logic [READING_W-1:0] temp_reading;

   modport source (output valid, input ready, output cmd, output volt_reading,
                   output temp_reading);
   modport sink   (input valid, output ready, input cmd, input volt_reading,
                   input temp_reading);
endinterface

interface tscc_rsp_if import tscc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [PHASE_W-1:0] phase;
   logic               charger_on;
   logic               alarm_led;
   logic               complete_led;
   logic               over_temp;

   modport source (output valid, input ready, output phase, output charger_on,
                   output alarm_led, output complete_led, output over_temp);
   modport sink   (input valid, output ready, input phase, input charger_on,
                   input alarm_led, input complete_led, input over_temp);
endinterface

>>> rtl/tscc_seq.sv
// ----------------------------------------------------------------------------
// tscc_seq
// Charge phase sequencer: state registers and their per-word update.
// ----------------------------------------------------------------------------
module tscc_seq import tscc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  logic [CMD_W-1:0]     cmd,
   input  logic [READING_W-1:0] volt_reading,
   input  logic [READING_W-1:0] temp_reading,
   input  cfg_type              cfg,
   output status_type           status_in
);

   phase_type            phase_ff, phase_in;
   logic [TICK_W-1:0]    tick_count_ff, tick_count_in;
   logic                 second_pending_ff, second_pending_in;
   logic                 disconnect_pending_ff, disconnect_pending_in;
   logic [SECONDS_W-1:0] absorb_count_ff, absorb_count_in;
   logic [SECONDS_W-1:0] float_count_ff, float_count_in;
   logic                 relay_ff, relay_in;
   logic                 alarm_ff, alarm_in;
   logic                 done_ff, done_in;
   logic                 temp_flag_ff, temp_flag_in;

   logic                 over_volt;
   logic                 over_temp;
   logic [TICK_W-1:0]    tick_inc;
   logic [SECONDS_W-1:0] absorb_inc;
   logic [SECONDS_W-1:0] float_inc;

   assign over_volt  = volt_reading >= cfg.overvolt_level;
   assign over_temp  = temp_reading >= cfg.overtemp_level;
   assign tick_inc   = tick_count_ff + TICK_W'(1);
   assign absorb_inc = sat_inc(absorb_count_ff);
   assign float_inc  = sat_inc(float_count_ff);

   always_comb begin
      phase_in              = phase_ff;
      tick_count_in         = tick_count_ff;
      second_pending_in     = second_pending_ff;
      disconnect_pending_in = disconnect_pending_ff;
      absorb_count_in       = absorb_count_ff;
      float_count_in        = float_count_ff;
      relay_in              = relay_ff;
      alarm_in              = alarm_ff;
      done_in               = done_ff;
      temp_flag_in          = temp_flag_ff;

      if (step_en) begin
         unique case (cmd_type'(cmd))
            CMD_SAMPLE: begin
               temp_flag_in = over_temp;
               if (disconnect_pending_ff) begin
                  disconnect_pending_in = 1'b0;
                  phase_in              = PH_DISCONNECT;
                  relay_in              = 1'b0;
                  alarm_in              = 1'b1;
               end
               if ((phase_in == PH_BULK || phase_in == PH_ABSORB || phase_in == PH_FLOAT)
                   && (over_volt || over_temp)) begin
                  phase_in = PH_ALARM;
                  relay_in = 1'b0;
                  alarm_in = 1'b1;
               end
               unique case (phase_in)
                  PH_IDLE: relay_in = 1'b0;
                  PH_BULK: begin
                     if (volt_reading >= cfg.absorb_volt_level) begin
                        phase_in        = PH_ABSORB;
                        absorb_count_in = '0;
                     end
                  end
                  PH_ABSORB: begin
                     if (second_pending_ff) begin
                        second_pending_in = 1'b0;
                        absorb_count_in   = absorb_inc;
                        if (absorb_inc >= cfg.absorb_seconds) begin
                           phase_in       = PH_FLOAT;
                           float_count_in = '0;
                        end
                     end
                  end
                  PH_FLOAT: begin
                     // trickle: marks are dropped, float never completes
                     if (cfg.trickle_mode) begin
                        second_pending_in = 1'b0;
                     end else if (second_pending_ff) begin
                        second_pending_in = 1'b0;
                        float_count_in    = float_inc;
                        if (float_inc >= cfg.float_seconds) begin
                           phase_in = PH_COMPLETE;
                           relay_in = 1'b0;
                           done_in  = 1'b1;
                        end
                     end
                  end
                  PH_ALARM: begin
                     if (!over_volt && !over_temp) begin
                        phase_in = PH_BULK;
                        relay_in = 1'b1;
                        alarm_in = 1'b0;
                     end
                  end
                  PH_COMPLETE, PH_DISCONNECT: begin
                  end
                  default: begin
                  end
               endcase
            end
            CMD_TICK: begin
               if (tick_inc >= cfg.ticks_per_second) begin
                  tick_count_in     = '0;
                  second_pending_in = 1'b1;
               end else begin
                  tick_count_in = tick_inc;
               end
            end
            CMD_DISCONNECT: disconnect_pending_in = 1'b1;
            CMD_START: begin
               if (phase_ff == PH_IDLE) begin
                  phase_in        = PH_BULK;
                  relay_in        = 1'b1;
                  absorb_count_in = '0;
                  float_count_in  = '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff              <= PH_IDLE;
         tick_count_ff         <= '0;
         second_pending_ff     <= 1'b0;
         disconnect_pending_ff <= 1'b0;
         absorb_count_ff       <= '0;
         float_count_ff        <= '0;
         relay_ff              <= 1'b0;
         alarm_ff              <= 1'b0;
         done_ff               <= 1'b0;
         temp_flag_ff          <= 1'b0;
      end else begin
         phase_ff              <= phase_in;
         tick_count_ff         <= tick_count_in;
         second_pending_ff     <= second_pending_in;
         disconnect_pending_ff <= disconnect_pending_in;
         absorb_count_ff       <= absorb_count_in;
         float_count_ff        <= float_count_in;
         relay_ff              <= relay_in;
         alarm_ff              <= alarm_in;
         done_ff               <= done_in;
         temp_flag_ff          <= temp_flag_in;
      end
   end

   assign status_in.phase        = phase_code(phase_in);
   assign status_in.charger_on   = relay_in;
   assign status_in.alarm_led    = alarm_in;
   assign status_in.complete_led = done_in;
   assign status_in.over_temp    = temp_flag_in;

endmodule

>>> rtl/three_stage_charge_controller_unit.sv
// ----------------------------------------------------------------------------
// three_stage_charge_controller_unit
// Bulk / absorption / float charge sequencer with alarm and disconnect.
// ----------------------------------------------------------------------------
// Takes one request word per clock while rsp_if is not stalled and returns
// exactly one response word per request, in order. A word passes an input
// register and then the result register, which drives the response word;
// the phase state updates once per word, which sets the rate at one word per
// cycle. Backpressure on rsp_if reaches req_if.ready in the same cycle. The
// user must write registers through the csr port only while no word is in
// flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module three_stage_charge_controller_unit import tscc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   tscc_req_if.sink              req_if,
   tscc_rsp_if.source            rsp_if,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   cfg_type              cfg_ff, cfg_in;

   logic                 s1_valid_ff, s1_valid_in;
   logic [CMD_W-1:0]     s1_cmd_ff;
   logic [READING_W-1:0] s1_volt_ff;
   logic [READING_W-1:0] s1_temp_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_ff;
   status_type           status_in;

   logic                 accept;
   logic                 advance;

   assign advance      = s1_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !s1_valid_ff || advance;
   assign accept       = req_if.valid && req_if.ready;
   assign s1_valid_in  = accept || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_if.ready);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_TRICKLE_MODE:      cfg_in.trickle_mode      = csr_wr_data[0];
            CSR_ABSORB_VOLT_LEVEL: cfg_in.absorb_volt_level = csr_wr_data[READING_W-1:0];
            CSR_OVERVOLT_LEVEL:    cfg_in.overvolt_level    = csr_wr_data[READING_W-1:0];
            CSR_OVERTEMP_LEVEL:    cfg_in.overtemp_level    = csr_wr_data[READING_W-1:0];
            CSR_ABSORB_SECONDS:    cfg_in.absorb_seconds    = csr_wr_data[SECONDS_W-1:0];
            CSR_FLOAT_SECONDS:     cfg_in.float_seconds     = csr_wr_data[SECONDS_W-1:0];
            CSR_TICKS_PER_SECOND:  cfg_in.ticks_per_second  = csr_wr_data[TICK_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trickle_mode      <= 1'b0;
         cfg_ff.absorb_volt_level <= RST_ABSORB_VOLT_LEVEL;
         cfg_ff.overvolt_level    <= RST_OVERVOLT_LEVEL;
         cfg_ff.overtemp_level    <= RST_OVERTEMP_LEVEL;
         cfg_ff.absorb_seconds    <= RST_ABSORB_SECONDS;
         cfg_ff.float_seconds     <= RST_FLOAT_SECONDS;
         cfg_ff.ticks_per_second  <= RST_TICKS_PER_SECOND;
         s1_valid_ff              <= 1'b0;
         rsp_valid_ff             <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff  <= req_if.cmd;
         s1_volt_ff <= req_if.volt_reading;
         s1_temp_ff <= req_if.temp_reading;
      end
      if (advance) begin
         rsp_ff <= status_in;
      end
   end

   tscc_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .step_en      (advance),
      .cmd          (s1_cmd_ff),
      .volt_reading (s1_volt_ff),
      .temp_reading (s1_temp_ff),
      .cfg          (cfg_ff),
      .status_in    (status_in)
   );

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.phase        = rsp_ff.phase;
   assign rsp_if.charger_on   = rsp_ff.charger_on;
   assign rsp_if.alarm_led    = rsp_ff.alarm_led;
   assign rsp_if.complete_led = rsp_ff.complete_led;
   assign rsp_if.over_temp    = rsp_ff.over_temp;

endmodule

>>> rtl/tscc_checker.sv
// ----------------------------------------------------------------------------
// tscc_checker
// Port-level assertions for the charge controller, bound to the top level.
// ----------------------------------------------------------------------------
module tscc_checker import tscc_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [PHASE_W-1:0] rsp_phase,
   input logic               rsp_charger_on,
   input logic               rsp_alarm_led,
   input logic               rsp_complete_led
);

   // a stalled response word holds its phase, charger and alarm fields
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_phase)
         && $stable(rsp_charger_on) && $stable(rsp_alarm_led))
      else $error("response word changed while stalled");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // relay drives only while actually charging
   a_relay_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_charger_on |-> rsp_phase == PHASE_CODE_BULK
         || rsp_phase == PHASE_CODE_ABSORB || rsp_phase == PHASE_CODE_FLOAT)
      else $error("charger on outside a charging phase");

   a_alarm_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_alarm_led |-> rsp_phase == PHASE_CODE_ALARM
         || rsp_phase == PHASE_CODE_DISCONNECT)
      else $error("alarm led outside alarm or disconnect");

   a_complete_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_complete_led |-> rsp_phase == PHASE_CODE_COMPLETE
         || rsp_phase == PHASE_CODE_DISCONNECT)
      else $error("complete led outside complete or disconnect");

endmodule

bind three_stage_charge_controller_unit tscc_checker u_tscc_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_phase        (rsp_if.phase),
   .rsp_charger_on   (rsp_if.charger_on),
   .rsp_alarm_led    (rsp_if.alarm_led),
   .rsp_complete_led (rsp_if.complete_led)
);
